// ===== src/srimt_pkg.sv =====
package srimt_pkg;

    localparam int DATA_W = 32;
    localparam int MOD_STAGES = 32;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO_STEP = 2'd2;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] locus;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] value;
    } rule_t;

    typedef struct packed {
        logic              cand;
        logic [DATA_W-1:0] dvd;
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] value;
    } mod_in_t;

    typedef struct packed {
        logic              cand;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] dvd;
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] value;
    } mod_stage_t;

    // one restoring division step, remainder stays below the divisor
    function automatic logic [DATA_W-1:0] rem_step(
        input logic [DATA_W-1:0] rem,
        input logic              bit_in,
        input logic [DATA_W-1:0] div
    );
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        trial = {rem, bit_in};
        diff = trial - {1'b0, div};
        if (trial >= {1'b0, div})
        begin
            return diff[DATA_W-1:0];
        end
        return trial[DATA_W-1:0];
    endfunction

endpackage

// ===== src/srimt_rule_mem.sv =====
module srimt_rule_mem
    import srimt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  rule_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output rule_t         rd_data
);

    rule_t mem [DEPTH];
    rule_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/srimt_mod_pipe.sv =====
module srimt_mod_pipe
    import srimt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_vld,
    input  mod_in_t    in_data,
    output logic       out_vld,
    output mod_stage_t out_data
);

    logic [MOD_STAGES-1:0] vld_reg;
    mod_stage_t            stg_reg [MOD_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[MOD_STAGES-2:0], in_vld};
        end
    end

    // stage i resolves dividend bit 31-i
    always_ff @(posedge clk)
    begin
        stg_reg[0].cand <= in_data.cand;
        stg_reg[0].step <= in_data.step;
        stg_reg[0].value <= in_data.value;
        stg_reg[0].rem <= rem_step('0, in_data.dvd[DATA_W-1], in_data.step);
        stg_reg[0].dvd <= {in_data.dvd[DATA_W-2:0], 1'b0};
        for (int i = 1; i < MOD_STAGES; i++)
        begin
            stg_reg[i].cand <= stg_reg[i-1].cand;
            stg_reg[i].step <= stg_reg[i-1].step;
            stg_reg[i].value <= stg_reg[i-1].value;
            stg_reg[i].rem <= rem_step(stg_reg[i-1].rem, stg_reg[i-1].dvd[DATA_W-1],
                                       stg_reg[i-1].step);
            stg_reg[i].dvd <= {stg_reg[i-1].dvd[DATA_W-2:0], 1'b0};
        end
    end

    assign out_vld = vld_reg[MOD_STAGES-1];
    assign out_data = stg_reg[MOD_STAGES-1];

endmodule

// ===== src/strided_id_range_match_table.sv =====
// insert: the rule is written and the result registered when the output is free
// lookup: the one-rule-per-cycle scan of the rule memory feeds the 32-stage remainder
// pipeline, and the result is registered once every issued rule has returned; the next
// transaction is taken at the edge the result can leave
// output stalls hold back the result; one transaction in flight at a time
// reset empties the table at once (rule count cleared), no clearing pass
module strided_id_range_match_table
    import srimt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              op,
    input  logic [DATA_W-1:0] query_id,
    input  logic [DATA_W-1:0] locus_key,
    input  logic [DATA_W-1:0] range_start,
    input  logic [DATA_W-1:0] range_count,
    input  logic [DATA_W-1:0] range_step,
    input  logic [DATA_W-1:0] rule_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] match_value,
    output logic              matched,
    output logic [1:0]        status
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_INS = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CNT_W-1:0]  rules_used_reg;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  ret_cnt_reg;
    logic              hit_reg;
    logic [DATA_W-1:0] hit_value_reg;
    logic              rd_pend_reg;

    logic              op_reg;
    logic [DATA_W-1:0] id_reg;
    rule_t             item_reg;

    logic              a_vld_reg;
    logic              a_loc_eq_reg;
    logic              a_ge_reg;
    logic [DATA_W:0]   a_end_reg;
    logic [DATA_W-1:0] a_diff_reg;
    logic [DATA_W-1:0] a_step_reg;
    logic [DATA_W-1:0] a_value_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] match_value_reg;
    logic              matched_reg;
    logic [1:0]        status_reg;

    logic              in_take;
    logic              out_free;
    logic              issue;
    logic              wr_en;
    logic              ins_load;
    logic              res_load;
    logic [1:0]        ins_status;
    rule_t             rd_data;
    mod_in_t           pipe_in;
    logic              pipe_vld;
    mod_stage_t        pipe_out;
    logic              pipe_hit;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign issue = (state_reg == S_SCAN) && (issue_cnt_reg < rules_used_reg);

    always_comb
    begin
        if (rules_used_reg >= FULL_CNT)
        begin
            ins_status = ST_FULL;
        end
        else if (item_reg.step == '0)
        begin
            ins_status = ST_ZERO_STEP;
        end
        else
        begin
            ins_status = ST_OK;
        end
    end

    assign ins_load = (state_reg == S_INS) && out_free;
    assign res_load = (state_reg == S_RESULT) && out_free;
    assign wr_en = ins_load && (ins_status == ST_OK);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (op == OP_INSERT) ? S_INS : S_SCAN;
                end
            end
            S_INS:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (ret_cnt_reg == rules_used_reg)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    srimt_rule_mem #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (rules_used_reg[IDX_W-1:0]),
        .wr_data (item_reg),
        .rd_en   (issue),
        .rd_addr (issue_cnt_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // range end is 33 bits wide so it never wraps
    assign pipe_in.cand = a_loc_eq_reg && a_ge_reg && ({1'b0, id_reg} < a_end_reg);
    assign pipe_in.dvd = a_diff_reg;
    assign pipe_in.step = a_step_reg;
    assign pipe_in.value = a_value_reg;

    srimt_mod_pipe u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (a_vld_reg),
        .in_data  (pipe_in),
        .out_vld  (pipe_vld),
        .out_data (pipe_out)
    );

    assign pipe_hit = pipe_vld && pipe_out.cand && (pipe_out.rem == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rules_used_reg <= '0;
            issue_cnt_reg <= '0;
            ret_cnt_reg <= '0;
            hit_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            a_vld_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_pend_reg <= issue;
            a_vld_reg <= rd_pend_reg;
            if (in_take)
            begin
                issue_cnt_reg <= '0;
                ret_cnt_reg <= '0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (pipe_vld)
                begin
                    ret_cnt_reg <= ret_cnt_reg + 1'b1;
                end
                if (pipe_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                rules_used_reg <= rules_used_reg + 1'b1;
            end
            if (ins_load || res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= op;
            id_reg <= query_id;
            item_reg.locus <= locus_key;
            item_reg.start <= range_start;
            item_reg.count <= range_count;
            item_reg.step <= range_step;
            item_reg.value <= rule_value;
        end
        // keep only the oldest matching rule
        if (pipe_hit && !hit_reg)
        begin
            hit_value_reg <= pipe_out.value;
        end
        a_loc_eq_reg <= (rd_data.locus == item_reg.locus);
        a_ge_reg <= (id_reg >= rd_data.start);
        a_end_reg <= {1'b0, rd_data.start} + {1'b0, rd_data.count};
        a_diff_reg <= id_reg - rd_data.start;
        a_step_reg <= rd_data.step;
        a_value_reg <= rd_data.value;
        if (ins_load)
        begin
            match_value_reg <= '0;
            matched_reg <= 1'b0;
            status_reg <= ins_status;
        end
        else if (res_load)
        begin
            match_value_reg <= hit_reg ? hit_value_reg : '0;
            matched_reg <= hit_reg;
            status_reg <= ST_OK;
        end
    end

    assign out_valid = out_valid_reg;
    assign match_value = match_value_reg;
    assign matched = matched_reg;
    assign status = status_reg;

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rules_used_reg <= FULL_CNT)
        else $error("rule count beyond table size");

    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rules_used_reg != $past(rules_used_reg)) |->
            (rules_used_reg == $past(rules_used_reg) + 1'b1))
        else $error("rule count changed by other than one");

    a_ret_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (ret_cnt_reg <= issue_cnt_reg))
        else $error("more rules returned than issued");

    a_write_only_ins: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (op_reg == OP_INSERT && item_reg.step != '0))
        else $error("rule written outside an accepted insert");

endmodule

// ===== tb/sv/tb_strided_id_range_match_table.sv =====
`timescale 1ns / 1ps

module tb_strided_id_range_match_table;
    import srimt_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] id;
        logic [DATA_W-1:0] locus;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] count;
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] value;
    } txn_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              hit;
        logic [1:0]        status;
    } answer_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              op = OP_LOOKUP;
    logic [DATA_W-1:0] query_id = '0;
    logic [DATA_W-1:0] locus_key = '0;
    logic [DATA_W-1:0] range_start = '0;
    logic [DATA_W-1:0] range_count = '0;
    logic [DATA_W-1:0] range_step = '0;
    logic [DATA_W-1:0] rule_value = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [DATA_W-1:0] match_value;
    logic              matched;
    logic [1:0]        status;

    // shadow copy of the rule table, updated when a transaction is taken
    logic [DATA_W-1:0] shadow_locus [TABLE_DEPTH];
    logic [DATA_W-1:0] shadow_start [TABLE_DEPTH];
    logic [DATA_W-1:0] shadow_count [TABLE_DEPTH];
    logic [DATA_W-1:0] shadow_step [TABLE_DEPTH];
    logic [DATA_W-1:0] shadow_value [TABLE_DEPTH];
    int                shadow_used = 0;

    logic [DATA_W-1:0] locus_pool [8];
    answer_t           pending_answers [$];

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold_cycles = 0;

    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int lookups_matched = 0;
    int lookups_missed = 0;
    int inserts_kept = 0;
    int inserts_full = 0;
    int inserts_zero_step = 0;

    strided_id_range_match_table #(
        .TABLE_ENTRIES(TABLE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .query_id(query_id),
        .locus_key(locus_key),
        .range_start(range_start),
        .range_count(range_count),
        .range_step(range_step),
        .rule_value(rule_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .match_value(match_value),
        .matched(matched),
        .status(status)
    );

    always #2 clk = ~clk;

    function automatic answer_t classify_and_store(input txn_t t);
        answer_t         a;
        logic [DATA_W:0] range_end;
        int              i;
        a = '0;
        a.status = ST_OK;
        if (t.op == OP_INSERT)
        begin
            if (shadow_used >= TABLE_DEPTH)
            begin
                a.status = ST_FULL;
                inserts_full++;
            end
            else if (t.step == '0)
            begin
                a.status = ST_ZERO_STEP;
                inserts_zero_step++;
            end
            else
            begin
                shadow_locus[shadow_used] = t.locus;
                shadow_start[shadow_used] = t.start;
                shadow_count[shadow_used] = t.count;
                shadow_step[shadow_used] = t.step;
                shadow_value[shadow_used] = t.value;
                shadow_used++;
                inserts_kept++;
            end
            return a;
        end
        for (i = 0; i < shadow_used; i++)
        begin
            // range end is 33 bits so a rule near the top of the id space never wraps
            range_end = {1'b0, shadow_start[i]} + {1'b0, shadow_count[i]};
            if (shadow_locus[i] == t.locus && t.id >= shadow_start[i] &&
                {1'b0, t.id} < range_end &&
                ((t.id - shadow_start[i]) % shadow_step[i]) == '0)
            begin
                a.value = shadow_value[i];
                a.hit = 1'b1;
                break;
            end
        end
        if (a.hit)
        begin
            lookups_matched++;
        end
        else
        begin
            lookups_missed++;
        end
        return a;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 93)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DATA_W-1:0] pick_locus();
        return locus_pool[$urandom_range(0, 7)];
    endfunction

    function automatic txn_t lookup_txn(input logic [DATA_W-1:0] id,
                                        input logic [DATA_W-1:0] locus);
        txn_t t;
        t.op = OP_LOOKUP;
        t.id = id;
        t.locus = locus;
        // fields a lookup ignores still get random content
        t.start = $urandom();
        t.count = $urandom();
        t.step = $urandom();
        t.value = $urandom();
        return t;
    endfunction

    function automatic txn_t insert_txn(input logic [DATA_W-1:0] locus,
                                        input logic [DATA_W-1:0] start,
                                        input logic [DATA_W-1:0] count,
                                        input logic [DATA_W-1:0] step,
                                        input logic [DATA_W-1:0] value);
        txn_t t;
        t.op = OP_INSERT;
        t.id = $urandom();
        t.locus = locus;
        t.start = start;
        t.count = count;
        t.step = step;
        t.value = value;
        return t;
    endfunction

    function automatic txn_t make_insert();
        txn_t t;
        int   idx;
        t = insert_txn(pick_locus(), $urandom(), $urandom_range(1, 300),
                       $urandom_range(1, 8), $urandom());
        if ($urandom_range(0, 9) == 0)
        begin
            t.locus = $urandom();
        end
        case ($urandom_range(0, 9))
            0, 1: t.start = $urandom_range(0, 1000);
            2: t.start = 32'hFFFF_FFFF - $urandom_range(0, 500);
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: t.count = '0;
            1: t.count = $urandom();
            2: t.count = 32'hFFFF_FFFF;
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1: t.step = 32'd1;
            2: t.step = $urandom();
            3: t.step = 32'hFFFF_FFFF;
            4: t.step = '0;
            5: t.step = $urandom_range(9, 100);
            default: ;
        endcase
        // shadowed rule: same locus and start as an older one, so first match decides
        if (shadow_used > 0 && $urandom_range(0, 7) == 0)
        begin
            idx = $urandom_range(0, shadow_used - 1);
            t.locus = shadow_locus[idx];
            t.start = shadow_start[idx];
            t.step = 32'd1;
        end
        return t;
    endfunction

    function automatic txn_t make_lookup(input bit well_formed);
        int              idx;
        longint unsigned lo;
        longint unsigned lim;
        longint unsigned nhits;
        longint unsigned id64;
        if (!well_formed || shadow_used == 0)
        begin
            return lookup_txn($urandom(), $urandom_range(0, 1) ? pick_locus() : $urandom());
        end
        idx = $urandom_range(0, shadow_used - 1);
        lo = shadow_start[idx];
        lim = lo + shadow_count[idx];
        if (lim > 64'hFFFF_FFFF)
        begin
            lim = 64'h1_0000_0000;
        end
        nhits = (lim - lo + shadow_step[idx] - 1) / shadow_step[idx];
        if (nhits == 0)
        begin
            id64 = lo;
        end
        else
        begin
            id64 = lo + longint'($urandom_range(0, 32'(nhits - 1))) * shadow_step[idx];
        end
        // near misses around a covered id and around the range end
        case ($urandom_range(0, 9))
            0: id64 = id64 + 1;
            1: id64 = id64 - 1;
            2: id64 = lim;
            3: id64 = lim - 1;
            default: ;
        endcase
        return lookup_txn(id64[DATA_W-1:0], shadow_locus[idx]);
    endfunction

    task automatic send_txn(input txn_t t);
        int gap;
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 2) == 0)
        begin
            gap = pick_len();
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= t.op;
        query_id <= t.id;
        locus_key <= t.locus;
        range_start <= t.start;
        range_count <= t.count;
        range_step <= t.step;
        rule_value <= t.value;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        pending_answers.insert(pending_answers.size(), classify_and_store(t));
        items_sent++;
    endtask

    task automatic wait_all_answered();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_answers.size() != 0);
    endtask

    task automatic test_empty_and_refusals();
        send_txn(lookup_txn('0, '0));
        send_txn(insert_txn(pick_locus(), 32'd10, 32'd10, '0, 32'h1234_5678));
    endtask

    task automatic test_range_edges();
        logic [DATA_W-1:0] key_a;
        key_a = locus_pool[2];
        send_txn(insert_txn(key_a, 32'd100, 32'd50, 32'd7, 32'hAAAA_5555));
        send_txn(lookup_txn(32'd100, key_a));
        send_txn(lookup_txn(32'd149, key_a));
        send_txn(lookup_txn(32'd101, key_a));
        send_txn(lookup_txn(32'd150, key_a));
        send_txn(lookup_txn(32'd99, key_a));
        // overlapping rule with value zero, older rule must win at id 100
        send_txn(insert_txn(key_a, 32'd100, 32'd10, 32'd1, '0));
        send_txn(lookup_txn(32'd100, key_a));
        send_txn(lookup_txn(32'd101, key_a));
        // range running past the top of the id space
        send_txn(insert_txn(32'hFFFF_FFFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'd1,
                            32'h5A5A_A5A5));
        send_txn(lookup_txn(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_txn(lookup_txn('0, 32'hFFFF_FFFF));
        send_txn(insert_txn('0, 32'd5, '0, 32'd1, 32'd1));
        send_txn(lookup_txn(32'd5, '0));
        send_txn(insert_txn('0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_txn(lookup_txn('0, '0));
        send_txn(lookup_txn(32'hFFFF_FFFF, '0));
        send_txn(lookup_txn(32'hFFFF_FFFE, '0));
        send_txn(lookup_txn(32'd100, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic(input int n_items, input int insert_pct);
        int n;
        for (n = 0; n < n_items; n++)
        begin
            // stretches with and without idling on both sides
            if (n % 80 == 0)
            begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < insert_pct)
            begin
                send_txn(make_insert());
            end
            else
            begin
                send_txn(make_lookup($urandom_range(0, 99) < 75));
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_output_hold_off();
        int n;
        rx_hold_cycles = 300;
        tx_idle_en = 1'b0;
        for (n = 0; n < 12; n++)
        begin
            send_txn(make_lookup(1'b1));
        end
        tx_idle_en = 1'b1;
        wait_all_answered();
    endtask

    task automatic test_table_full();
        int n;
        while (shadow_used < TABLE_DEPTH)
        begin
            send_txn(make_insert());
        end
        // full is reported ahead of zero step
        send_txn(insert_txn(pick_locus(), $urandom(), 32'd10, '0, $urandom()));
        send_txn(insert_txn(pick_locus(), $urandom(), 32'd10, 32'd1, $urandom()));
        for (n = 0; n < 10; n++)
        begin
            send_txn(make_lookup(1'b1));
        end
    endtask

    initial
    begin : rx_stall_gen
        int run_left;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                rx_hold_cycles--;
                run_left = 0;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                run_left = pick_len() - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                run_left = rx_idle_en ? $urandom_range(0, 4) : 0;
            end
        end
    end

    initial
    begin : result_checker
        answer_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected transaction: match_value %h matched %0b status %0d",
                             $time, match_value, matched, status);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    results_checked++;
                    if (match_value !== want.value)
                    begin
                        errors++;
                        $display("%0t: match_value expected %h actual %h",
                                 $time, want.value, match_value);
                    end
                    if (matched !== want.hit)
                    begin
                        errors++;
                        $display("%0t: matched expected %0b actual %0b",
                                 $time, want.hit, matched);
                    end
                    if (status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : main_seq
        int k;
        locus_pool[0] = '0;
        locus_pool[1] = 32'hFFFF_FFFF;
        locus_pool[2] = 32'h0000_1111;
        for (k = 3; k < 8; k++)
        begin
            locus_pool[k] = $urandom();
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_refusals();
        test_range_edges();
        wait_all_answered();
        test_random_traffic(360, 12);
        test_output_hold_off();
        test_table_full();
        wait_all_answered();
        test_random_traffic(220, 25);
        wait_all_answered();
        repeat (120) @(posedge clk);
        errors += pending_answers.size();

        $display("%0d transactions sent, %0d results checked, %0d rules stored",
                 items_sent, results_checked, shadow_used);
        $display("lookups hit %0d missed %0d, inserts kept %0d, refused full %0d zero step %0d",
                 lookups_matched, lookups_missed, inserts_kept, inserts_full,
                 inserts_zero_step);
        if (errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== strided_id_range_match_table.f =====
src/srimt_pkg.sv
src/srimt_rule_mem.sv
src/srimt_mod_pipe.sv
src/strided_id_range_match_table.sv
tb/sv/tb_strided_id_range_match_table.sv
